### rtl/utilization_token_throttle_top_macros.svh
// Assertion macros for the token throttle.
`ifndef UTILIZATION_TOKEN_THROTTLE_TOP_MACROS_SVH
`define UTILIZATION_TOKEN_THROTTLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define UTT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define UTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define UTT_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define UTT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/utt_pkg.sv
`default_nettype none
package utt_pkg;

   localparam int SAMPLE_WINDOW  = 30;
   localparam int FREE_THRESHOLD = 5;
   localparam int FULL_UTIL      = 100;
   localparam int HALF_WINDOW    = SAMPLE_WINDOW / 2;
   localparam int STEP_SHIFT     = 8;
   localparam int MIN_DIFF       = 5;
   localparam int NUM_W          = 40;
   localparam int CNT_W          = 6;

   localparam logic [2:0] CSR_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_HARD      = 3'd1;
   localparam logic [2:0] CSR_TARGET    = 3'd2;
   localparam logic [2:0] CSR_CEILING   = 3'd3;
   localparam logic [2:0] CSR_SM_COUNT  = 3'd4;
   localparam logic [2:0] CSR_TPS       = 3'd5;
   localparam logic [2:0] CSR_TOKEN_CAP = 3'd6;

   localparam logic [1:0] STATUS_SAMPLE   = 2'd0;
   localparam logic [1:0] STATUS_ADMITTED = 2'd1;
   localparam logic [1:0] STATUS_HELD     = 2'd2;

   typedef struct packed {
      logic load;
      logic pre;
      logic mul1;
      logic mul2;
      logic mul3;
      logic mul4;
      logic scale;
      logic div_step;
      logic apply;
   } cmd_type;

   typedef struct packed {
      logic is_launch;
      logic wide;
   } sts_type;

   // Quotient by ten of a 7-bit value.
   function automatic logic [6:0] div10(input logic [6:0] x);
      logic [17:0] p;
      p = 18'(x) * 18'd205;
      return p[17:11];
   endfunction

endpackage
`default_nettype wire

### rtl/utt_ctrl.sv
`default_nettype none
`include "utilization_token_throttle_top_macros.svh"
module utt_ctrl
   import utt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_PRE   = 9'b000000010,
      ST_MUL1  = 9'b000000100,
      ST_MUL2  = 9'b000001000,
      ST_MUL3  = 9'b000010000,
      ST_MUL4  = 9'b000100000,
      ST_SCALE = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_APPLY = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PRE;
            end
         end
         ST_PRE: begin
            cmd.pre  = 1'b1;
            state_in = sts.is_launch ? ST_APPLY : ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul3 = 1'b1;
            state_in = ST_MUL4;
         end
         ST_MUL4: begin
            cmd.mul4 = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            cnt_in    = CNT_W'(NUM_W - 1);
            state_in  = sts.wide ? ST_DIV : ST_APPLY;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (slot_free) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `UTT_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && !req_stall, state_ff == ST_PRE)
   `UTT_ASSERT_IMPLIES(a_rsp_from_apply, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_APPLY))
   `UTT_ASSERT_NEXT(a_div_ends, clock, reset, state_ff == ST_DIV && cnt_ff == '0, state_ff == ST_APPLY)

endmodule
`default_nettype wire

### rtl/utt_dp.sv
`default_nettype none
module utt_dp
   import utt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_write_data,
   input  wire logic        req_kind,
   input  wire logic [9:0]  req_user_util,
   input  wire logic [9:0]  req_sys_util,
   input  wire logic [10:0] req_process_count,
   input  wire logic [30:0] req_launch_blocks,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_tokens,
   output logic [30:0]      rsp_share
);

   // Configuration.
   logic        enable_ff, hard_ff;
   logic [6:0]  target_ff, ceiling_ff;
   logic [7:0]  sm_ff;
   logic [12:0] tps_ff;
   logic [30:0] cap_ff;

   // Architectural state.
   logic signed [31:0] pool_ff, pool_in;
   logic [30:0]        share_ff, share_in;
   logic [6:0]         eff_ff, eff_in;
   logic [7:0]         wc_ff, wc_in;
   logic signed [19:0] acc_ff, acc_in;
   logic [10:0]        ppc_ff, ppc_in;

   // Request and work registers.
   logic        kind_ff;
   logic [9:0]  user_ff, sys_ff;
   logic [10:0] pc_ff;
   logic [30:0] blocks_ff;
   logic [6:0]  limit_ff;
   logic [9:0]  diff_ff;
   logic        wide_ff, startup_ff;
   logic [15:0] p1_ff;
   logic [28:0] p2_ff;
   logic [30:0] p3_ff;
   logic [63:0] p4_ff;
   logic [NUM_W-1:0] num_ff;
   logic [7:0]  rem_ff;

   // Sample pre-processing.
   logic               rise;
   logic [30:0]        share_a;
   logic [6:0]         eff_a, eff_b, limit_c;
   logic [7:0]         wc_a, wc_b;
   logic signed [19:0] acc_a, acc_b;
   logic signed [11:0] free_util;
   logic [7:0]         ceil_up;
   logic [9:0]         diff_c, diff_raw;
   logic               startup_c;

   always_comb begin
      rise     = ppc_ff < pc_ff;
      share_a  = share_ff;
      eff_a    = eff_ff;
      wc_a     = wc_ff;
      acc_a    = acc_ff;
      if (!hard_ff && rise) begin
         share_a = 31'(tps_ff);
         eff_a   = target_ff;
         wc_a    = '0;
         acc_a   = '0;
      end
      free_util = 12'(FULL_UTIL) - 12'(sys_ff);
      eff_b    = eff_a;
      wc_b     = wc_a;
      acc_b    = acc_a;
      ceil_up  = 8'(eff_a) + 8'(div10(target_ff));
      if (!hard_ff && pc_ff != 11'd1) begin
         wc_b  = wc_a + 8'd1;
         acc_b = acc_a + 20'(free_util);
         if (wc_b == 8'(SAMPLE_WINDOW)) begin
            // Truncated average above threshold, written as a constant compare.
            if (acc_b >= $signed(20'((FREE_THRESHOLD + 1) * HALF_WINDOW))) begin
               eff_b = (ceil_up > 8'(ceiling_ff)) ? ceiling_ff : ceil_up[6:0];
            end
            wc_b = '0;
         end
         if (wc_b == 8'd0 || wc_b == 8'(HALF_WINDOW) || wc_b == 8'(2 * HALF_WINDOW)) begin
            acc_b = '0;
         end
      end
      if (hard_ff) begin
         limit_c = target_ff;
      end else if (pc_ff == 11'd1) begin
         limit_c = ceiling_ff;
      end else begin
         limit_c = eff_b;
      end
      diff_raw  = (10'(limit_c) > user_ff) ? 10'(limit_c) - user_ff
                                           : user_ff - 10'(limit_c);
      diff_c    = (diff_raw < 10'(MIN_DIFF)) ? 10'(MIN_DIFF) : diff_raw;
      startup_c = hard_ff && pc_ff == 11'd1 && user_ff < 10'(div10(eff_ff));
   end

   // Divider step by limit + 1.
   logic [8:0] div_d, div_r;
   logic       div_ge;
   assign div_d  = 9'(limit_ff) + 9'd1;
   assign div_r  = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge = div_r >= div_d;

   // Final share and pool.
   logic [NUM_W-1:0]   inc_full;
   logic [NUM_W:0]     up_sum;
   logic [30:0]        step_val;
   logic signed [32:0] add_sum, sub_sum;
   always_comb begin
      inc_full = wide_ff ? num_ff : NUM_W'(p4_ff[63:35]);
      up_sum   = (NUM_W+1)'(share_ff) + (NUM_W+1)'(inc_full);
      if (10'(limit_ff) >= user_ff) begin
         step_val = (up_sum > (NUM_W+1)'(cap_ff)) ? cap_ff : up_sum[30:0];
      end else begin
         step_val = (inc_full > NUM_W'(share_ff)) ? 31'd0 : share_ff - inc_full[30:0];
      end
      add_sum = 33'(pool_ff) + $signed({2'b00, step_val});
      sub_sum = 33'(pool_ff) - $signed({2'b00, blocks_ff});
   end

   always_comb begin
      pool_in  = pool_ff;
      share_in = share_ff;
      eff_in   = eff_ff;
      wc_in    = wc_ff;
      acc_in   = acc_ff;
      ppc_in   = ppc_ff;
      if (cmd.pre && !kind_ff) begin
         share_in = share_a;
         eff_in   = eff_b;
         wc_in    = wc_b;
         acc_in   = acc_b;
         if (!hard_ff) begin
            ppc_in = pc_ff;
         end
      end
      if (cmd.apply) begin
         if (!kind_ff) begin
            if (startup_ff) begin
               pool_in = $signed({1'b0, step_val});
            end else begin
               share_in = step_val;
               pool_in  = (add_sum > $signed({2'b00, cap_ff})) ? $signed({1'b0, cap_ff})
                                                               : add_sum[31:0];
            end
         end else if (enable_ff && !pool_ff[31]) begin
            pool_in = (sub_sum < -33'sd2147483648) ? 32'sh80000000 : sub_sum[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b1;
         hard_ff    <= 1'b0;
         target_ff  <= 7'd50;
         ceiling_ff <= 7'd100;
         sm_ff      <= 8'd80;
         tps_ff     <= 13'd2048;
         cap_ff     <= 31'd5242880;
         pool_ff    <= '0;
         share_ff   <= '0;
         eff_ff     <= 7'd50;
         wc_ff      <= '0;
         acc_ff     <= '0;
         ppc_ff     <= 11'd1;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ENABLE:    enable_ff  <= csr_write_data[0];
               CSR_HARD:      hard_ff    <= csr_write_data[0];
               CSR_TARGET:    target_ff  <= csr_write_data[6:0];
               CSR_CEILING:   ceiling_ff <= csr_write_data[6:0];
               CSR_SM_COUNT:  sm_ff      <= csr_write_data[7:0];
               CSR_TPS:       tps_ff     <= csr_write_data[12:0];
               CSR_TOKEN_CAP: cap_ff     <= csr_write_data;
               default: begin
               end
            endcase
         end
         pool_ff  <= pool_in;
         share_ff <= share_in;
         eff_ff   <= eff_in;
         wc_ff    <= wc_in;
         acc_ff   <= acc_in;
         ppc_ff   <= ppc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         user_ff   <= req_user_util;
         sys_ff    <= req_sys_util;
         pc_ff     <= req_process_count;
         blocks_ff <= req_launch_blocks;
      end
      if (cmd.pre) begin
         limit_ff   <= limit_c;
         diff_ff    <= diff_c;
         wide_ff    <= diff_c > 10'(limit_c[6:1]);
         startup_ff <= startup_c;
      end
      if (cmd.mul1) p1_ff <= 16'(sm_ff) * 16'(sm_ff);
      if (cmd.mul2) p2_ff <= 29'(p1_ff) * 29'(tps_ff);
      if (cmd.mul3) p3_ff <= 31'(p2_ff[28:STEP_SHIFT]) * 31'(diff_ff);
      // Division by ten through the reciprocal, exact for 32-bit operands.
      if (cmd.mul4) p4_ff <= 64'(p3_ff) * 64'h00000000CCCCCCCD;
      if (cmd.scale) begin
         num_ff <= {NUM_W'(p4_ff[63:35]) * NUM_W'(diff_ff)} << 1;
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= div_ge ? 8'(div_r - div_d) : div_r[7:0];
         num_ff <= {num_ff[NUM_W-2:0], div_ge};
      end
      if (cmd.apply) begin
         if (!kind_ff) begin
            rsp_status <= STATUS_SAMPLE;
         end else if (enable_ff && pool_ff[31]) begin
            rsp_status <= STATUS_HELD;
         end else begin
            rsp_status <= STATUS_ADMITTED;
         end
         rsp_tokens <= pool_in;
         rsp_share  <= share_in;
      end
   end

   assign sts.is_launch = kind_ff;
   assign sts.wide      = wide_ff;

endmodule
`default_nettype wire

### rtl/utilization_token_throttle_top.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  kind, user_util, sys_util, process_count,
//                                           launch_blocks
// rsp_      out        rsp_valid/rsp_stall  status, tokens, share
// csr_      in         csr_write_enable     csr_index, csr_write_data
//
// A launch result passes through PRE and APPLY, a sample result through PRE, MUL1 to
// MUL4, SCALE and APPLY, adding DIV when the error is large, since the widened step
// runs a restoring divider that retires one quotient bit per cycle. The next request
// is taken once the controller is back in IDLE, so requests do not overlap.
// Synchronous active-high reset restores configuration and state, not data registers.
// A new request is taken while a finished result still waits on rsp_stall.
module utilization_token_throttle_top
   import utt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [30:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [9:0]  req_user_util,
   input  wire logic [9:0]  req_sys_util,
   input  wire logic [10:0] req_process_count,
   input  wire logic [30:0] req_launch_blocks,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_tokens,
   output logic [30:0]      rsp_share
);

   cmd_type cmd;
   sts_type sts;

   utt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   utt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_kind          (req_kind),
      .req_user_util     (req_user_util),
      .req_sys_util      (req_sys_util),
      .req_process_count (req_process_count),
      .req_launch_blocks (req_launch_blocks),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_status        (rsp_status),
      .rsp_tokens        (rsp_tokens),
      .rsp_share         (rsp_share)
   );

endmodule
`default_nettype wire
